// ----- sv/lsat_pkg.sv -----
// shared types, constants and helpers of the line stream ack phase tracker
package lsat_pkg;

  // width of the job total and of the line counters
  localparam int unsigned COUNT_BITS = 24;
  // fixed widths of the request and result fields
  localparam int unsigned LINE_BITS  = 24;
  localparam int unsigned OUT_BITS   = 24;
  localparam int unsigned CMD_BITS   = 4;
  localparam int unsigned KIND_BITS  = 3;
  localparam int unsigned PHASE_BITS = 3;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [OUT_BITS-1:0]   out_count_t;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_START      = 4'd0,
    CMD_LINE       = 4'd1,
    CMD_REPLY      = 4'd2,
    CMD_FAIL       = 4'd3,
    CMD_PAUSE      = 4'd4,
    CMD_RESUME     = 4'd5,
    CMD_CANCEL     = 4'd6,
    CMD_CHECK      = 4'd7,
    CMD_DISCONNECT = 4'd8
  } cmd_e;

  typedef enum logic [KIND_BITS-1:0] {
    REPLY_OK      = 3'd0,
    REPLY_ERROR   = 3'd1,
    REPLY_ALARM   = 3'd2,
    REPLY_STATUS  = 3'd3,
    REPLY_INFO    = 3'd4,
    REPLY_UNKNOWN = 3'd5
  } reply_e;

  typedef enum logic [PHASE_BITS-1:0] {
    PH_IDLE     = 3'd0,
    PH_RUN      = 3'd1,
    PH_PAUSE    = 3'd2,
    PH_CANCEL   = 3'd3,
    PH_COMPLETE = 3'd4,
    PH_ERROR    = 3'd5,
    PH_ALARM    = 3'd6
  } phase_e;

  // one registered request
  typedef struct packed {
    cmd_e                 command;
    logic [LINE_BITS-1:0] job_lines;
    reply_e               reply_kind;
  } req_t;

  // one result item
  typedef struct packed {
    phase_e     phase;
    out_count_t written;
    out_count_t acked;
    out_count_t in_flight;
    logic       may_feed;
    logic       may_resume;
    logic       terminal;
    logic       accepted;
  } result_t;

  // job total from the request field, zero extended or truncated
  function automatic count_t lines_to_count(input logic [LINE_BITS-1:0] v);
    logic [LINE_BITS+COUNT_BITS-1:0] ext;
    ext = {{COUNT_BITS{1'b0}}, v};
    return ext[COUNT_BITS-1:0];
  endfunction

  // counter shown in the low result bits
  function automatic out_count_t count_to_out(input count_t v);
    logic [OUT_BITS+COUNT_BITS-1:0] ext;
    ext = {{OUT_BITS{1'b0}}, v};
    return ext[OUT_BITS-1:0];
  endfunction

endpackage

// ----- sv/lsat_in_stage.sv -----
// request input register with valid/ready handshake
module lsat_in_stage (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [lsat_pkg::CMD_BITS-1:0]   command_i,
  input  logic [lsat_pkg::LINE_BITS-1:0]  job_lines_i,
  input  logic [lsat_pkg::KIND_BITS-1:0]  reply_kind_i,
  input  logic                            take_i,
  output logic                            req_valid_o,
  output lsat_pkg::req_t                  req_o
);
  import lsat_pkg::*;

  logic valid_q, valid_d;
  req_t req_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q.command    <= cmd_e'(command_i);
      req_q.job_lines  <= job_lines_i;
      req_q.reply_kind <= reply_e'(reply_kind_i);
    end
  end

  assign req_valid_o = valid_q;
  assign req_o       = req_q;

endmodule

// ----- sv/lsat_state.sv -----
// phase and line counter state with the per request update logic
module lsat_state (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  lsat_pkg::req_t    req_i,
  output lsat_pkg::result_t res_o
);
  import lsat_pkg::*;

  phase_e phase_q, phase_d;
  count_t total_q, total_d;
  count_t written_q, written_d;
  count_t acked_q, acked_d;
  logic   accepted;
  logic   feed_now;
  logic   active_now;
  count_t diff;

  assign feed_now   = (phase_q == PH_RUN) && (written_q < total_q);
  assign active_now = (phase_q == PH_RUN) || (phase_q == PH_PAUSE) ||
                      (phase_q == PH_CANCEL);

  // command decode
  always_comb begin
    phase_d   = phase_q;
    total_d   = total_q;
    written_d = written_q;
    acked_d   = acked_q;
    accepted  = 1'b0;
    unique case (req_i.command)
      CMD_START: begin
        phase_d   = PH_RUN;
        total_d   = lines_to_count(req_i.job_lines);
        written_d = '0;
        acked_d   = '0;
      end
      CMD_LINE: begin
        if (feed_now) begin
          written_d = written_q + count_t'(1);
        end
      end
      CMD_REPLY: begin
        unique case (req_i.reply_kind)
          REPLY_OK: begin
            if (acked_q < written_q) begin
              acked_d = acked_q + count_t'(1);
            end
          end
          REPLY_ERROR: phase_d = PH_ERROR;
          REPLY_ALARM: phase_d = PH_ALARM;
          default: ;
        endcase
      end
      CMD_FAIL: phase_d = PH_ERROR;
      CMD_PAUSE: begin
        if (phase_q == PH_RUN) begin
          phase_d = PH_PAUSE;
        end
      end
      CMD_RESUME: begin
        if (phase_q == PH_PAUSE) begin
          phase_d  = PH_RUN;
          accepted = 1'b1;
        end
      end
      CMD_CANCEL: begin
        if ((phase_q == PH_RUN) || (phase_q == PH_PAUSE)) begin
          phase_d  = PH_CANCEL;
          accepted = 1'b1;
        end
      end
      CMD_CHECK: begin
        if (active_now && (written_q >= total_q) && (acked_q >= total_q)) begin
          phase_d = PH_COMPLETE;
        end
      end
      CMD_DISCONNECT: begin
        phase_d   = PH_IDLE;
        total_d   = '0;
        written_d = '0;
        acked_d   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      total_q   <= '0;
      written_q <= '0;
      acked_q   <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      total_q   <= total_d;
      written_q <= written_d;
      acked_q   <= acked_d;
    end
  end

  // result shows the state after this request
  assign diff = (written_d > acked_d) ? (written_d - acked_d) : '0;

  always_comb begin
    res_o.phase      = phase_d;
    res_o.written    = count_to_out(written_d);
    res_o.acked      = count_to_out(acked_d);
    res_o.in_flight  = count_to_out(diff);
    res_o.may_feed   = (phase_d == PH_RUN) && (written_d < total_d);
    res_o.may_resume = (phase_d == PH_PAUSE);
    res_o.terminal   = (phase_d == PH_COMPLETE) || (phase_d == PH_ERROR) ||
                       (phase_d == PH_ALARM);
    res_o.accepted   = accepted;
  end

`ifndef ASSERT_OFF
  a_acked_le_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acked_q <= written_q)
    else $error("acked count above written count");

  a_written_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    written_q <= total_q)
    else $error("written count above job total");

  a_accept_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.accepted |=> (phase_q == PH_RUN) || (phase_q == PH_CANCEL))
    else $error("accepted request left wrong phase");

  a_complete_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (phase_q != PH_COMPLETE) && (phase_d == PH_COMPLETE)
    |=> (written_q >= total_q) && (acked_q >= total_q))
    else $error("complete with lines outstanding");
`endif

endmodule

// ----- sv/lsat_out_stage.sv -----
// result register with valid/ready handshake
module lsat_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  lsat_pkg::result_t res_i,
  output logic              take_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lsat_pkg::result_t res_o
);
  import lsat_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign take_o  = !valid_q || out_ready_i;
  assign valid_d = take_o ? res_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && take_o) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- sv/line_stream_ack_phase_tracker.sv -----
// top level of the line stream ack phase tracker
// a request is held in the request register, and its result is then held in the result register
// throughput: one request per cycle, sustained while out_ready_i stays high
// the state update sits between the request register and the result register
// reset (rst_ni low, asynchronous) clears both valid flags and sets phase idle, counts zero
module line_stream_ack_phase_tracker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [lsat_pkg::CMD_BITS-1:0]    command_i,
  input  logic [lsat_pkg::LINE_BITS-1:0]   job_lines_i,
  input  logic [lsat_pkg::KIND_BITS-1:0]   reply_kind_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [lsat_pkg::PHASE_BITS-1:0]  phase_now_o,
  output logic [lsat_pkg::OUT_BITS-1:0]    written_count_o,
  output logic [lsat_pkg::OUT_BITS-1:0]    acked_count_o,
  output logic [lsat_pkg::OUT_BITS-1:0]    in_flight_o,
  output logic                             may_feed_o,
  output logic                             may_resume_o,
  output logic                             terminal_o,
  output logic                             accepted_o
);
  import lsat_pkg::*;

  // registered request and its valid flag
  logic    req_valid;
  req_t    req;
  // result register can take a new item this cycle
  logic    take;
  // result computed from the registered request and current state
  result_t res_next;
  result_t res;

  // request stage: refills whenever the result register moves
  lsat_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .job_lines_i  (job_lines_i),
    .reply_kind_i (reply_kind_i),
    .take_i       (take),
    .req_valid_o  (req_valid),
    .req_o        (req)
  );

  // state commits exactly when the request moves into the result register,
  // so back to back requests always see the state left by the one before
  lsat_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (req_valid && take),
    .req_i  (req),
    .res_o  (res_next)
  );

  // result stage: holds a finished result while the consumer stalls
  lsat_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (req_valid),
    .res_i       (res_next),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  // unpack the result onto its ports
  assign phase_now_o     = res.phase;
  assign written_count_o = res.written;
  assign acked_count_o   = res.acked;
  assign in_flight_o     = res.in_flight;
  assign may_feed_o      = res.may_feed;
  assign may_resume_o    = res.may_resume;
  assign terminal_o      = res.terminal;
  assign accepted_o      = res.accepted;

`ifndef ASSERT_OFF
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(res))
    else $error("result changed while stalled");

  a_req_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && take |=> out_valid_o)
    else $error("request lost between stages");

  a_feed_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && may_feed_o |-> res.phase == PH_RUN)
    else $error("feed allowed outside running");
`endif

endmodule
